/* rtl/npc_pkg.sv */
// Shared types and constants for the nearest palette color search block.
// Used by npc_dist and the top level; has no dependencies of its own.
`default_nettype none

package npc_pkg;

    // Default palette depth; the top level hands its parameter down.
    localparam int PALETTE_DEPTH_DEF = 256;

    // Field widths.
    localparam int CH_W    = 8;
    localparam int COLOR_W = 3 * CH_W;
    localparam int IDX_W   = 8;
    localparam int SIZE_W  = 9;

    // An 8-bit index reaches this many slots.
    localparam int INDEX_SPAN = 2 ** IDX_W;

    // Squared distance over three channels: 3 * 255^2 fits in 18 bits.
    localparam int DIST_W = 18;

    // Command codes.
    localparam logic CMD_WRITE    = 1'b0;
    localparam logic CMD_CLASSIFY = 1'b1;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    // A palette read in flight toward the distance unit.
    typedef struct packed {
        logic             vld;
        logic [IDX_W-1:0] idx;
    } rd_tag_t;

    // Registered result of the distance unit.
    typedef struct packed {
        logic              vld;
        logic [IDX_W-1:0]  idx;
        logic [DIST_W-1:0] distance;
    } dist_word_t;

endpackage

`default_nettype wire

/* rtl/npc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Has no dependencies; instanced for the palette store.
`default_nettype none

module npc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* rtl/npc_dist.sv */
// Shared distance unit: squared Euclidean distance of one palette entry
// to the pixel, one entry per cycle, registered. Depends on npc_pkg.
`default_nettype none

module npc_dist (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire npc_pkg::rd_tag_t         tag,
    input  wire logic [npc_pkg::COLOR_W-1:0] entry,
    input  wire logic [npc_pkg::COLOR_W-1:0] pixel,
    output npc_pkg::dist_word_t           result
);
    import npc_pkg::*;

    logic [CH_W-1:0]     ch_e [3];
    logic [CH_W-1:0]     ch_p [3];
    logic [CH_W-1:0]     diff [3];
    logic [2*CH_W-1:0]   sq   [3];
    logic [DIST_W-1:0]   dist_sum;
    logic                vld_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [DIST_W-1:0]   dist_reg;

    // Absolute difference and square per channel.
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            ch_e[c] = entry[c*CH_W +: CH_W];
            ch_p[c] = pixel[c*CH_W +: CH_W];
            diff[c] = (ch_e[c] > ch_p[c]) ? (ch_e[c] - ch_p[c]) : (ch_p[c] - ch_e[c]);
            sq[c]   = diff[c] * diff[c];
        end
        dist_sum = DIST_W'(sq[0]) + DIST_W'(sq[1]) + DIST_W'(sq[2]);
    end

    // Valid flag of the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= tag.vld;
        end
    end

    // Payload of the output register.
    always_ff @(posedge clk)
    begin
        idx_reg  <= tag.idx;
        dist_reg <= dist_sum;
    end

    assign result.vld      = vld_reg;
    assign result.idx      = idx_reg;
    assign result.distance = dist_reg;

endmodule

`default_nettype wire

/* rtl/nearest_palette_color_search.sv */
// Top level of the nearest palette color search: sequencer, palette RAM,
// shared distance unit and best-match tracking. Depends on npc_pkg,
// npc_ram and npc_dist.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one word per command.
//   A write word (command 0) stores {red, green, blue} at entry_index and is
//   taken with no result; slots at or beyond PALETTE_DEPTH are
//   not stored. A classify word (command 1) carries a pixel; the block reads
//   slots 0 .. palette_size-1 one per cycle through the palette RAM port and
//   the distance unit, and returns the lowest index with the smallest
//   squared distance on the output channel (out_valid / out_stall).
//   After a classify is accepted and its scan ends, the result is loaded into
//   the output register and the input is open again; the palette RAM read
//   port, one slot per cycle, sets the pace of the scan.
//   in_stall is high while a classify is in progress. A result waits in the
//   output register while out_stall is high; new write words are still taken
//   then, and a following classify holds its result until the register frees.
//   palette_size (cfg_wr_en / cfg_wr_data) is 1 after reset; 0 acts as 1 and
//   larger values saturate at the smaller of PALETTE_DEPTH and 256.
//   Reset leaves palette contents undefined until written.
`default_nettype none

module nearest_palette_color_search #(
    parameter int PALETTE_DEPTH = npc_pkg::PALETTE_DEPTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_wr_en,
    input  wire logic [npc_pkg::SIZE_W-1:0]   cfg_wr_data,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic                         command,
    input  wire logic [npc_pkg::IDX_W-1:0]    entry_index,
    input  wire logic [npc_pkg::CH_W-1:0]     red,
    input  wire logic [npc_pkg::CH_W-1:0]     green,
    input  wire logic [npc_pkg::CH_W-1:0]     blue,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [npc_pkg::IDX_W-1:0]         color_index
);
    import npc_pkg::*;

    localparam int AW = $clog2(PALETTE_DEPTH);
    localparam logic [SIZE_W-1:0] SEARCH_CAP =
        SIZE_W'((PALETTE_DEPTH < INDEX_SPAN) ? PALETTE_DEPTH : INDEX_SPAN);

    state_t              state_reg, state_next;
    logic [SIZE_W-1:0]   size_reg, size_next;
    logic [SIZE_W-1:0]   lim_reg, lim_next;
    logic [SIZE_W-1:0]   issue_cnt_reg, issue_cnt_next;
    logic                rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0]    rd_idx_reg, rd_idx_next;
    logic [COLOR_W-1:0]  pix_reg, pix_next;
    logic                found_reg, found_next;
    logic [IDX_W-1:0]    best_idx_reg, best_idx_next;
    logic [DIST_W-1:0]   best_dist_reg, best_dist_next;
    logic                out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]    out_color_reg, out_color_next;

    logic                in_accept;
    logic [SIZE_W-1:0]   lim_calc;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [AW-1:0]       ram_raddr;
    logic [COLOR_W-1:0]  ram_rdata;
    rd_tag_t             rd_tag;
    dist_word_t          dist_out;

    // Handshake and palette write path.
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign ram_we    = in_accept && (command == CMD_WRITE)
                       && (32'(entry_index) < PALETTE_DEPTH);
    assign ram_waddr = AW'(entry_index);
    assign ram_raddr = AW'(issue_cnt_reg);

    // Effective search length from the size register.
    always_comb
    begin
        if (size_reg == '0)
        begin
            lim_calc = SIZE_W'(1);
        end
        else if (size_reg > SEARCH_CAP)
        begin
            lim_calc = SEARCH_CAP;
        end
        else
        begin
            lim_calc = size_reg;
        end
    end

    npc_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({red, green, blue}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_tag.vld = rd_vld_reg;
    assign rd_tag.idx = rd_idx_reg;

    npc_dist u_dist (
        .clk    (clk),
        .rst_n  (rst_n),
        .tag    (rd_tag),
        .entry  (ram_rdata),
        .pixel  (pix_reg),
        .result (dist_out)
    );

    // Sequencer, best-match tracking and output register control.
    always_comb
    begin
        state_next     = state_reg;
        size_next      = size_reg;
        lim_next       = lim_reg;
        issue_cnt_next = issue_cnt_reg;
        rd_vld_next    = 1'b0;
        rd_idx_next    = rd_idx_reg;
        pix_next       = pix_reg;
        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        best_dist_next = best_dist_reg;
        out_valid_next = out_valid_reg;
        out_color_next = out_color_reg;

        if (cfg_wr_en)
        begin
            size_next = cfg_wr_data;
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        // Keep the first slot seen and any strictly closer one after it.
        if (dist_out.vld && (!found_reg || (dist_out.distance < best_dist_reg)))
        begin
            found_next     = 1'b1;
            best_idx_next  = dist_out.idx;
            best_dist_next = dist_out.distance;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (command == CMD_CLASSIFY))
                begin
                    pix_next       = {red, green, blue};
                    lim_next       = lim_calc;
                    issue_cnt_next = '0;
                    found_next     = 1'b0;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (issue_cnt_reg < lim_reg)
                begin
                    rd_vld_next    = 1'b1;
                    rd_idx_next    = issue_cnt_reg[IDX_W-1:0];
                    issue_cnt_next = issue_cnt_reg + SIZE_W'(1);
                end
                else if (!rd_vld_reg && !dist_out.vld)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_color_next = best_idx_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            size_reg      <= SIZE_W'(1);
            lim_reg       <= SIZE_W'(1);
            issue_cnt_reg <= '0;
            rd_vld_reg    <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            size_reg      <= size_next;
            lim_reg       <= lim_next;
            issue_cnt_reg <= issue_cnt_next;
            rd_vld_reg    <= rd_vld_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        rd_idx_reg    <= rd_idx_next;
        pix_reg       <= pix_next;
        best_idx_reg  <= best_idx_next;
        best_dist_reg <= best_dist_next;
        out_color_reg <= out_color_next;
    end

    assign out_valid   = out_valid_reg;
    assign color_index = out_color_reg;

`ifndef SYNTHESIS
    // A result is loaded only on leaving the finishing state.
    a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result loaded outside the finishing state");

    // The scan never issues past its limit, and the limit stays in range.
    a_scan_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (issue_cnt_reg <= lim_reg) && (lim_reg != '0)
        && (lim_reg <= SEARCH_CAP))
        else $error("scan counter or limit out of range");

    // The palette is never written while a scan reads it.
    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_IDLE))
        else $error("palette write during a scan");

    // Distances only arrive while scanning.
    a_dist_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        dist_out.vld |-> (state_reg == ST_SCAN))
        else $error("distance word outside a scan");
`endif

endmodule

`default_nettype wire
